// ----- rtl/core/gqc_pkg.sv -----
// Package for the glyph quad clipper: shared types, widths and constants.
// Used by every module under rtl/core.
`default_nettype none
package gqc_pkg;

   localparam int MAX_SCALE      = 64;
   localparam int TEX_FRAC_BITS  = 16;
   localparam int NUM_W          = 20;            // divider numerator / denominator
   localparam int STEPS_PER_CYC  = 4;             // quotient bits per divider cycle
   localparam int DIV_CYCLES     = TEX_FRAC_BITS / STEPS_PER_CYC;
   localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
   localparam int VERTS          = 6;
   localparam int VERT_CNT_W     = $clog2(VERTS);
   localparam logic [16:0] TEX_ONE   = 17'(1) << TEX_FRAC_BITS;
   localparam logic [15:0] CLIP_BIAS = 16'd16384;

   // register map, index = paddr[3:2]
   localparam logic [1:0] REG_TARGET_W = 2'd0;
   localparam logic [1:0] REG_TARGET_H = 2'd1;
   localparam logic [1:0] REG_ATLAS_W  = 2'd2;
   localparam logic [1:0] REG_ATLAS_H  = 2'd3;

   typedef struct packed {
      logic signed [15:0] dst_left;
      logic signed [15:0] dst_top;
      logic signed [15:0] dst_right;
      logic signed [15:0] dst_bottom;
      logic [11:0]        src_left;
      logic [11:0]        src_top;
      logic [6:0]         glyph_scale;
      logic [31:0]        color_rgba;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] clip_x;
      logic signed [15:0] clip_y;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [31:0]        vertex_color;
      logic               last_vertex;
   } rsp_item_type;

   typedef struct packed {
      logic [14:0] target_width;
      logic [14:0] target_height;
      logic [12:0] atlas_width;
      logic [12:0] atlas_height;
   } cfg_type;

   // one classified glyph, ready for division
   typedef struct packed {
      logic [NUM_W-1:0] num_u0;
      logic [NUM_W-1:0] num_u1;
      logic [NUM_W-1:0] num_v0;
      logic [NUM_W-1:0] num_v1;
      logic [NUM_W-1:0] den_u;
      logic [NUM_W-1:0] den_v;
      logic [14:0]      px0;
      logic [14:0]      px1;
      logic [14:0]      py0;
      logic [14:0]      py1;
      logic [31:0]      color;
   } glyph_type;

   // vertex corner order (x0,y0) (x1,y0) (x0,y1) (x0,y1) (x1,y0) (x1,y1)
   function automatic logic sel_x(input logic [VERT_CNT_W-1:0] k);
      logic r;
      case (k)
         3'd1, 3'd4, 3'd5: r = 1'b1;
         default:          r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic sel_y(input logic [VERT_CNT_W-1:0] k);
      logic r;
      case (k)
         3'd2, 3'd3, 3'd5: r = 1'b1;
         default:          r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/glyph_quad_clip_vertex_gen_core.sv -----
// Glyph quad clipper and vertex generator: top level with register port.
// Depends on gqc_pkg, gqc_front, gqc_queue, gqc_back.
//
// A glyph is taken when start is high and busy low; a kept glyph produces six
// vertices on consecutive cycles, flagged by rsp_valid, which the receiver
// must take as they come. Glyphs that clip away produce nothing. Sustained
// throughput is set by the vertex emitter; the first vertex follows
// acceptance through the queue, the eight 4-bit-per-cycle dividers and the
// transfer register. Division of the next glyph overlaps emission of the
// current one; busy rises when the two-entry queue is full. Registers must
// be written only while idle; the block itself does not enforce this.
`default_nettype none
module glyph_quad_clip_vertex_gen_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire gqc_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   output gqc_pkg::rsp_item_type      rsp_item,
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire [3:0]                  paddr,
   input  wire [31:0]                 pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import gqc_pkg::*;

   cfg_type   cfg_ff;
   logic      wr_en;
   logic      keep, q_full, q_not_empty, q_pop;
   glyph_type glyph, q_data;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_width  <= '0;
         cfg_ff.target_height <= '0;
         cfg_ff.atlas_width   <= 13'd1;
         cfg_ff.atlas_height  <= 13'd1;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_TARGET_W: cfg_ff.target_width  <= pwdata[14:0];
            REG_TARGET_H: cfg_ff.target_height <= pwdata[14:0];
            REG_ATLAS_W:  cfg_ff.atlas_width   <= pwdata[12:0];
            REG_ATLAS_H:  cfg_ff.atlas_height  <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TARGET_W: prdata = 32'(cfg_ff.target_width);
         REG_TARGET_H: prdata = 32'(cfg_ff.target_height);
         REG_ATLAS_W:  prdata = 32'(cfg_ff.atlas_width);
         REG_ATLAS_H:  prdata = 32'(cfg_ff.atlas_height);
         default:      prdata = '0;
      endcase
   end

   assign busy = q_full;

   gqc_front u_front (
      .item  (req_item),
      .cfg   (cfg_ff),
      .keep  (keep),
      .glyph (glyph)
   );

   gqc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !q_full && keep),
      .push_data (glyph),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   gqc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule
`default_nettype wire

// ----- rtl/core/gqc_front.sv -----
// Front end: clamps the glyph rectangle, drops empty glyphs and forms the
// divider operands. Depends on gqc_pkg.
`default_nettype none
module gqc_front (
   input  wire gqc_pkg::req_item_type item,
   input  wire gqc_pkg::cfg_type      cfg,
   output logic                       keep,
   output gqc_pkg::glyph_type         glyph
);
   import gqc_pkg::*;

   function automatic logic [14:0] clamp_edge(input logic signed [15:0] v,
                                              input logic [14:0] hi);
      logic [14:0] r;
      if (v < 0)
         r = '0;
      else if (v > $signed({1'b0, hi}))
         r = hi;
      else
         r = v[14:0];
      return r;
   endfunction

   logic [6:0]        scale;
   logic [12:0]       aw, ah;
   logic [14:0]       vx0, vx1, vy0, vy1;
   logic signed [16:0] dx0, dx1, dy0, dy1;
   logic [18:0]       sl_s, st_s;

   always_comb begin
      scale = item.glyph_scale;
      if (scale == 7'd0)
         scale = 7'd1;
      else if (scale > 7'(MAX_SCALE))
         scale = 7'(MAX_SCALE);
      aw = (cfg.atlas_width  == '0) ? 13'd1 : cfg.atlas_width;
      ah = (cfg.atlas_height == '0) ? 13'd1 : cfg.atlas_height;

      vx0 = clamp_edge(item.dst_left,   cfg.target_width);
      vx1 = clamp_edge(item.dst_right,  cfg.target_width);
      vy0 = clamp_edge(item.dst_top,    cfg.target_height);
      vy1 = clamp_edge(item.dst_bottom, cfg.target_height);

      keep = (cfg.target_width != '0) && (cfg.target_height != '0) &&
             (vx0 < vx1) && (vy0 < vy1);

      // offsets are non-negative whenever the glyph is kept
      dx0 = $signed({2'b00, vx0}) - 17'(item.dst_left);
      dx1 = $signed({2'b00, vx1}) - 17'(item.dst_left);
      dy0 = $signed({2'b00, vy0}) - 17'(item.dst_top);
      dy1 = $signed({2'b00, vy1}) - 17'(item.dst_top);

      sl_s = 19'(item.src_left) * 19'(scale);
      st_s = 19'(item.src_top)  * 19'(scale);

      glyph.num_u0 = NUM_W'(sl_s) + NUM_W'(dx0[15:0]);
      glyph.num_u1 = NUM_W'(sl_s) + NUM_W'(dx1[15:0]);
      glyph.num_v0 = NUM_W'(st_s) + NUM_W'(dy0[15:0]);
      glyph.num_v1 = NUM_W'(st_s) + NUM_W'(dy1[15:0]);
      glyph.den_u  = NUM_W'(scale) * NUM_W'(aw);
      glyph.den_v  = NUM_W'(scale) * NUM_W'(ah);
      glyph.px0    = vx0;
      glyph.px1    = vx1;
      glyph.py0    = vy0;
      glyph.py1    = vy1;
      glyph.color  = item.color_rgba;
   end

endmodule
`default_nettype wire

// ----- rtl/core/gqc_queue.sv -----
// Two-entry queue of classified glyphs between front and back end.
// Depends on gqc_pkg.
`default_nettype none
module gqc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire gqc_pkg::glyph_type push_data,
   output logic                   full,
   output logic                   not_empty,
   input  wire                    pop,
   output gqc_pkg::glyph_type     pop_data
);
   import gqc_pkg::*;

   glyph_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ----- rtl/core/gqc_fdiv.sv -----
// Fractional divider: floor(num * 2^16 / den) for num < den, saturating to
// 1.0 when num >= den. Several quotient bits per cycle. Depends on gqc_pkg.
`default_nettype none
module gqc_fdiv (
   input  wire                      clock,
   input  wire                      load,
   input  wire                      step,
   input  wire [gqc_pkg::NUM_W-1:0] num,
   input  wire [gqc_pkg::NUM_W-1:0] den,
   output logic [16:0]              quo
);
   import gqc_pkg::*;

   logic [NUM_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         den_ff;
   logic [TEX_FRAC_BITS-1:0] q_ff, q_in;
   logic                     sat_ff;
   logic [NUM_W:0]           t;

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      t      = '0;
      for (int i = 0; i < STEPS_PER_CYC; i++) begin
         t = {rem_in, 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t    = t - {1'b0, den_ff};
            q_in = {q_in[TEX_FRAC_BITS-2:0], 1'b1};
         end else begin
            q_in = {q_in[TEX_FRAC_BITS-2:0], 1'b0};
         end
         rem_in = t[NUM_W-1:0];
      end
   end

   assign quo = sat_ff ? TEX_ONE : {1'b0, q_ff};

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= num;
         den_ff <= den;
         sat_ff <= (num >= den);
         q_ff   <= '0;
      end else if (step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/gqc_back.sv -----
// Back end: eight fractional dividers in lockstep, then a six-vertex emitter
// that overlaps with the next glyph's division. Depends on gqc_pkg, gqc_fdiv.
`default_nettype none
module gqc_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire gqc_pkg::cfg_type   cfg,
   input  wire                     q_not_empty,
   input  wire gqc_pkg::glyph_type q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   output gqc_pkg::rsp_item_type   rsp_item
);
   import gqc_pkg::*;

   logic                  div_run_ff, div_run_in;
   logic                  div_full_ff, div_full_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [31:0]           div_color_ff;
   logic                  emit_on_ff, emit_on_in;
   logic [VERT_CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic                  transfer;

   logic [NUM_W-1:0] dnum [8];
   logic [NUM_W-1:0] dden [8];
   logic [16:0]      dq   [8];
   logic [16:0]      res_ff [8];   // u0 u1 v0 v1 x0 x1 y0 y1
   logic [31:0]      color_ff;

   always_comb begin
      dnum[0] = q_data.num_u0;         dden[0] = q_data.den_u;
      dnum[1] = q_data.num_u1;         dden[1] = q_data.den_u;
      dnum[2] = q_data.num_v0;         dden[2] = q_data.den_v;
      dnum[3] = q_data.num_v1;         dden[3] = q_data.den_v;
      dnum[4] = NUM_W'(q_data.px0);    dden[4] = NUM_W'(cfg.target_width);
      dnum[5] = NUM_W'(q_data.px1);    dden[5] = NUM_W'(cfg.target_width);
      dnum[6] = NUM_W'(q_data.py0);    dden[6] = NUM_W'(cfg.target_height);
      dnum[7] = NUM_W'(q_data.py1);    dden[7] = NUM_W'(cfg.target_height);
   end

   for (genvar g = 0; g < 8; g++) begin : g_div
      gqc_fdiv u_div (
         .clock (clock),
         .load  (q_pop),
         .step  (div_run_ff),
         .num   (dnum[g]),
         .den   (dden[g]),
         .quo   (dq[g])
      );
   end

   always_comb begin
      transfer = div_full_ff &&
                 (!emit_on_ff || emit_cnt_ff == VERT_CNT_W'(VERTS - 1));
      q_pop = q_not_empty && !div_run_ff && (!div_full_ff || transfer);

      div_run_in  = div_run_ff;
      div_cnt_in  = div_cnt_ff;
      div_full_in = div_full_ff && !transfer;
      if (q_pop) begin
         div_run_in = 1'b1;
         div_cnt_in = '0;
      end else if (div_run_ff) begin
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            div_run_in  = 1'b0;
            div_full_in = 1'b1;
         end
      end

      emit_on_in  = emit_on_ff;
      emit_cnt_in = emit_cnt_ff;
      if (transfer) begin
         emit_on_in  = 1'b1;
         emit_cnt_in = '0;
      end else if (emit_on_ff) begin
         emit_cnt_in = emit_cnt_ff + 1'b1;
         if (emit_cnt_ff == VERT_CNT_W'(VERTS - 1))
            emit_on_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff  <= 1'b0;
         div_full_ff <= 1'b0;
         div_cnt_ff  <= '0;
         emit_on_ff  <= 1'b0;
         emit_cnt_ff <= '0;
      end else begin
         div_run_ff  <= div_run_in;
         div_full_ff <= div_full_in;
         div_cnt_ff  <= div_cnt_in;
         emit_on_ff  <= emit_on_in;
         emit_cnt_ff <= emit_cnt_in;
      end
      if (q_pop)
         div_color_ff <= q_data.color;
      if (transfer) begin
         for (int i = 0; i < 8; i++)
            res_ff[i] <= dq[i];
         color_ff <= div_color_ff;
      end
   end

   // clip = floor(2^15 * p / size) - 2^14; divider gives 2^16 * p / size
   function automatic logic [15:0] to_clip(input logic [16:0] q);
      return q[16:1] - CLIP_BIAS;
   endfunction

   logic sx, sy;
   always_comb begin
      sx = sel_x(emit_cnt_ff);
      sy = sel_y(emit_cnt_ff);
      rsp_valid             = emit_on_ff;
      rsp_item.tex_u        = sx ? res_ff[1] : res_ff[0];
      rsp_item.tex_v        = sy ? res_ff[3] : res_ff[2];
      rsp_item.clip_x       = to_clip(sx ? res_ff[5] : res_ff[4]);
      rsp_item.clip_y       = to_clip(sy ? res_ff[7] : res_ff[6]);
      rsp_item.vertex_color = color_ff;
      rsp_item.last_vertex  = (emit_cnt_ff == VERT_CNT_W'(VERTS - 1));
   end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for glyph_quad_clip_vertex_gen_core: glyphs are driven through the
// start/busy port, vertices are predicted in-bench and compared per field.
// Depends on gqc_pkg and the core RTL.
`timescale 1ns / 100ps
module tb;
   import gqc_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   glyph_quad_clip_vertex_gen_core uut (.*);

   always #2 clock = ~clock;

   // predictor copy of the register file
   logic [14:0]  tgt_w = '0, tgt_h = '0;
   logic [12:0]  atl_w = 13'd1, atl_h = 13'd1;
   rsp_item_type vertex_q[$];
   int           errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [15:0] clip_coord(input longint p, input longint size);
      return 16'((p * 32768) / size - 16384);
   endfunction

   function automatic logic [16:0] tex_coord(input longint src, input longint d,
                                              input longint scl, input longint atl);
      longint q;
      q = ((src * scl + d) << TEX_FRAC_BITS) / (scl * atl);
      if (q > (longint'(1) << TEX_FRAC_BITS)) q = longint'(1) << TEX_FRAC_BITS;
      return 17'(q);
   endfunction

   function automatic longint clamp_px(input longint v, input longint hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
   endfunction

   task automatic predict_glyph(input req_item_type g);
      longint x0, y0, x1, y1, vx0, vy0, vx1, vy1, scl, aw, ah;
      logic [15:0] cx[2], cy[2];
      logic [16:0] u[2], v[2];
      rsp_item_type r;
      if (tgt_w == 0 || tgt_h == 0) return;
      x0 = g.dst_left; y0 = g.dst_top; x1 = g.dst_right; y1 = g.dst_bottom;
      scl = g.glyph_scale;
      if (scl < 1) scl = 1;
      if (scl > MAX_SCALE) scl = MAX_SCALE;
      aw = atl_w ? atl_w : 1;
      ah = atl_h ? atl_h : 1;
      vx0 = clamp_px(x0, tgt_w); vx1 = clamp_px(x1, tgt_w);
      vy0 = clamp_px(y0, tgt_h); vy1 = clamp_px(y1, tgt_h);
      if (vx0 >= vx1 || vy0 >= vy1) return;
      u[0] = tex_coord(g.src_left, vx0 - x0, scl, aw);
      u[1] = tex_coord(g.src_left, vx1 - x0, scl, aw);
      v[0] = tex_coord(g.src_top, vy0 - y0, scl, ah);
      v[1] = tex_coord(g.src_top, vy1 - y0, scl, ah);
      cx[0] = clip_coord(vx0, tgt_w); cx[1] = clip_coord(vx1, tgt_w);
      cy[0] = clip_coord(vy0, tgt_h); cy[1] = clip_coord(vy1, tgt_h);
      for (int k = 0; k < VERTS; k++) begin
         r.clip_x       = cx[sel_x(3'(k))];
         r.clip_y       = cy[sel_y(3'(k))];
         r.tex_u        = u[sel_x(3'(k))];
         r.tex_v        = v[sel_y(3'(k))];
         r.vertex_color = g.color_rgba;
         r.last_vertex  = (k == VERTS - 1);
         vertex_q = {vertex_q, r};
      end
   endtask

   // vertex checker
   always @(posedge clock) begin
      rsp_item_type w;
      if (!reset && rsp_valid) begin
         if (vertex_q.size() == 0) begin
            report("unexpected vertex", 1, 0);
         end else begin
            w = vertex_q.pop_front();
            if (rsp_item.clip_x !== w.clip_x) report("clip_x", rsp_item.clip_x, w.clip_x);
            if (rsp_item.clip_y !== w.clip_y) report("clip_y", rsp_item.clip_y, w.clip_y);
            if (rsp_item.tex_u !== w.tex_u) report("tex_u", rsp_item.tex_u, w.tex_u);
            if (rsp_item.tex_v !== w.tex_v) report("tex_v", rsp_item.tex_v, w.tex_v);
            if (rsp_item.vertex_color !== w.vertex_color)
               report("vertex_color", rsp_item.vertex_color, w.vertex_color);
            if (rsp_item.last_vertex !== w.last_vertex)
               report("last_vertex", rsp_item.last_vertex, w.last_vertex);
         end
      end
   end

   // drops start, then waits for every expected vertex
   task automatic wait_drain();
      start <= 1'b0;
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_TARGET_W: tgt_w = val[14:0];
         REG_TARGET_H: tgt_h = val[14:0];
         REG_ATLAS_W:  atl_w = val[12:0];
         default:      atl_h = val[12:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input int tw, input int th, input int aw, input int ah);
      wait_drain();
      csr_write(REG_TARGET_W, tw);
      csr_write(REG_TARGET_H, th);
      csr_write(REG_ATLAS_W, aw);
      csr_write(REG_ATLAS_H, ah);
   endtask

   // send one glyph; gap drawn per item unless told none. start stays high
   // after the accepting edge so a following item can go out without a gap.
   task automatic send_glyph(input req_item_type g, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1; req_item <= g;
      // busy is sampled mid-cycle, ahead of the edge it qualifies
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_glyph(g);
   endtask

   function automatic req_item_type rand_glyph(input bit raw);
      req_item_type g;
      int l, t;
      g.src_left = 12'($urandom); g.src_top = 12'($urandom);
      g.glyph_scale = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 8));
      g.color_rgba = $urandom;
      if (raw) begin
         g.dst_left = 16'($urandom); g.dst_top = 16'($urandom);
         g.dst_right = 16'($urandom); g.dst_bottom = 16'($urandom);
      end else begin
         // mostly boxes that straddle or sit inside the target
         l = int'($urandom_range(0, tgt_w + 80)) - 40;
         t = int'($urandom_range(0, tgt_h + 80)) - 40;
         g.dst_left = 16'(l); g.dst_top = 16'(t);
         g.dst_right = 16'(l + int'($urandom_range(1, 120)));
         g.dst_bottom = 16'(t + int'($urandom_range(1, 120)));
      end
      return g;
   endfunction

   function automatic req_item_type mk(input int l, input int t, input int r, input int b,
                                       input int sl, input int st, input int sc);
      req_item_type g;
      g.dst_left = 16'(l); g.dst_top = 16'(t); g.dst_right = 16'(r); g.dst_bottom = 16'(b);
      g.src_left = 12'(sl); g.src_top = 12'(st); g.glyph_scale = 7'(sc);
      g.color_rgba = $urandom;
      return g;
   endfunction

   task automatic test_zero_target();
      // reset config, then zero target width, then zero target height: nothing comes out
      send_glyph(mk(0, 0, 10, 10, 0, 0, 1));
      set_config(0, 100, 64, 64);
      send_glyph(mk(0, 0, 10, 10, 0, 0, 1));
      set_config(100, 0, 64, 64);
      send_glyph(mk(0, 0, 10, 10, 0, 0, 1));
   endtask

   task automatic test_directed();
      set_config(640, 480, 512, 256);
      send_glyph(mk(10, 20, 18, 36, 100, 200, 1));
      send_glyph(mk(-8, -8, 8, 8, 4, 4, 2));              // clipped top-left
      send_glyph(mk(630, 470, 700, 500, 4095, 4095, 64)); // clipped bottom-right
      send_glyph(mk(-32768, -32768, 32767, 32767, 0, 0, 0)); // scale zero
      send_glyph(mk(0, 0, 16, 16, 7, 7, 127));            // scale saturates
      send_glyph(mk(10, 10, 10, 20, 0, 0, 1));            // empty width
      send_glyph(mk(20, 20, 10, 10, 0, 0, 1));            // inverted box
      send_glyph(mk(700, 0, 800, 10, 0, 0, 1));           // fully outside
      send_glyph(mk(0, 0, 640, 480, 4095, 4095, 1));      // tex saturates
      set_config(16384, 16384, 4096, 4096);
      send_glyph(mk(0, 0, 16384, 16384, 0, 0, 1));
      send_glyph(mk(-1, 16383, 32767, 32767, 4095, 0, 64));
      set_config(1, 1, 0, 0);                              // atlas zero as one
      send_glyph(mk(0, 0, 1, 1, 0, 0, 1));
      send_glyph(mk(-5, -5, 5, 5, 1, 1, 3));
      set_config(32767, 32767, 8191, 8191);                // register width extremes
      send_glyph(mk(0, 0, 32767, 32767, 4095, 4095, 1));
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++)
         send_glyph(rand_glyph($urandom_range(0, 7) == 0));
   endtask

   task automatic test_back_to_back();
      for (int i = 0; i < 20; i++) send_glyph(rand_glyph(1'b0), 1'b1);
      wait_drain();   // sender holds until all vertices are out
      for (int i = 0; i < 10; i++) send_glyph(rand_glyph(1'b0), 1'b1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_target();
      test_directed();
      set_config(320, 200, 128, 64);
      test_random(100);
      test_back_to_back();
      set_config($urandom_range(1, 2000), $urandom_range(1, 2000),
                 $urandom_range(1, 4096), $urandom_range(1, 4096));
      test_random(100);
      set_config(7, 3, 1, 4096);
      test_random(60);
      wait_drain();
      if (errors == 0)
         $display("[glyph_quad_clip_vertex_gen_core] OK");
      else
         $display("[glyph_quad_clip_vertex_gen_core] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[glyph_quad_clip_vertex_gen_core] ERROR");
      $finish;
   end
endmodule
